// ----- src/bmpd_pkg.sv -----
// ----------------------------------------------------------------------------
// bmpd_pkg
// Shared types, header layout constants and helpers for the BMP pixel decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bmpd_pkg;

  // Image size limits; dimension registers are sized to hold the larger one
  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned DIM_MAX    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int unsigned DIM_W      = $clog2(DIM_MAX + 1);
  typedef logic [DIM_W-1:0] dim_t;

  // Palette memory
  localparam int unsigned PAL_DEPTH = 256;
  localparam int unsigned PAL_AW    = $clog2(PAL_DEPTH);
  localparam int unsigned RGB_W     = 24;
  typedef logic [PAL_AW-1:0] pal_addr_t;
  typedef logic [RGB_W-1:0]  rgb_t;

  // File layout
  localparam logic [31:0] HDR_END   = 32'd30;
  localparam logic [31:0] PAL_BASE  = 32'd54;
  localparam logic [31:0] PAL_END_4 = PAL_BASE + 32'd4 * 32'd16;
  localparam logic [31:0] PAL_END_8 = PAL_BASE + 32'd4 * 32'd256;
  localparam logic [15:0] BPP_4     = 16'd4;
  localparam logic [15:0] BPP_8     = 16'd8;
  localparam logic [7:0]  SIG_B     = 8'h42;
  localparam logic [7:0]  SIG_M     = 8'h4D;

  // Header byte positions
  localparam logic [4:0] POS_SIG1 = 5'd1;
  localparam logic [4:0] POS_OFS0 = 5'd10;
  localparam logic [4:0] POS_OFS1 = 5'd11;
  localparam logic [4:0] POS_OFS2 = 5'd12;
  localparam logic [4:0] POS_OFS3 = 5'd13;
  localparam logic [4:0] POS_WID0 = 5'd18;
  localparam logic [4:0] POS_WID1 = 5'd19;
  localparam logic [4:0] POS_WID2 = 5'd20;
  localparam logic [4:0] POS_WID3 = 5'd21;
  localparam logic [4:0] POS_HGT0 = 5'd22;
  localparam logic [4:0] POS_HGT1 = 5'd23;
  localparam logic [4:0] POS_HGT2 = 5'd24;
  localparam logic [4:0] POS_HGT3 = 5'd25;
  localparam logic [4:0] POS_BPP0 = 5'd28;
  localparam logic [4:0] POS_BPP1 = 5'd29;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_SIGNATURE = 2'd1,
    ERR_SIZE      = 2'd2,
    ERR_OFFSET    = 2'd3
  } err_e;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] column;
    logic [11:0] image_row;
    logic        last_pixel;
    err_e        error_code;
  } beat_t;

  // Output queue (power of two depth)
  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_AW    = $clog2(OQ_DEPTH);
  typedef logic [OQ_AW-1:0] oq_ptr_t;
  typedef logic [OQ_AW:0]   oq_cnt_t;

  // Place byte k of a little-endian 32-bit field into a dim_t register
  function automatic dim_t dim_merge(dim_t v, logic [1:0] k, logic [7:0] b);
    dim_t        r;
    int unsigned idx;
    r = v;
    for (int unsigned j = 0; j < 8; j++) begin
      idx = 32'd8 * 32'(k) + j;
      if (idx < DIM_W) r[idx] = b[j];
    end
    return r;
  endfunction

  // Any bit of byte k that lands above the dim_t register
  function automatic logic dim_spill(logic [1:0] k, logic [7:0] b);
    logic        s;
    int unsigned idx;
    s = 1'b0;
    for (int unsigned j = 0; j < 8; j++) begin
      idx = 32'd8 * 32'(k) + j;
      if (idx >= DIM_W) s = s | b[j];
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- src/bmpd_ram.sv -----
// ----------------------------------------------------------------------------
// bmpd_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bmpd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

// ----- src/bmpd_out_fifo.sv -----
// ----------------------------------------------------------------------------
// bmpd_out_fifo
// Result queue; takes up to two beats per cycle, delivers one per cycle while ready_i is high.
// ----------------------------------------------------------------------------
`default_nettype none

module bmpd_out_fifo
  import bmpd_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  [1:0] push_n_i,
  input  wire beat_t beat0_i,
  input  wire beat_t beat1_i,
  output logic       valid_o,
  input  wire logic  ready_i,
  output beat_t      head_o,
  output oq_cnt_t    count_o
);

  beat_t   mem_q [OQ_DEPTH];
  oq_ptr_t wr_q, wr_d, rd_q, rd_d;
  oq_cnt_t cnt_q, cnt_d;
  oq_ptr_t wr_p1;
  logic    pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign count_o = cnt_q;
  assign wr_p1   = wr_q + oq_ptr_t'(1);

  always_comb begin
    wr_d  = wr_q + oq_ptr_t'(push_n_i);
    rd_d  = pop ? rd_q + oq_ptr_t'(1) : rd_q;
    cnt_d = cnt_q + oq_cnt_t'(push_n_i) - oq_cnt_t'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) mem_q[wr_q]  <= beat0_i;
    if (push_n_i == 2'd2) mem_q[wr_p1] <= beat1_i;
  end

endmodule

`default_nettype wire

// ----- src/bmp_stream_pixel_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// bmp_stream_pixel_decoder_unit
// Streaming BMP decoder: header parse, palette load, pixel expansion.
// ----------------------------------------------------------------------------
// Input channel: one file byte per beat, start_of_file_i on byte 0 restarts
// the parse. Output channel: one pixel or error result per beat, with column,
// row (zero at top) and a last-pixel flag on the final top-row pixel.
// A result passes through the result stage (registered alongside the palette
// memory read) and then the result queue before it reaches the output.
// Throughput: one byte per cycle for header, palette, 8 bpp and 24 bpp data
// while in_ready_o is high. A 4 bpp byte yields two pixels, and the output
// port moves one per cycle, so when both pixels are valid 4 bpp input
// outruns the output. The four-entry result queue throttles it: in_ready_o
// is high while the queue plus the stage in flight leave room for two
// more results. When the receiver stalls, the queue fills and in_ready_o
// drops; nothing is dropped. Reset clears the parse state and the queue;
// palette contents are undefined until a file loads them. Errors (bad
// signature, oversize image, data offset inside the header or palette)
// give one result, then the rest is ignored until the next start_of_file_i.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_stream_pixel_decoder_unit
  import bmpd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  file_byte_i,
  input  wire logic        start_of_file_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       red_o,
  output logic [7:0]       green_o,
  output logic [7:0]       blue_o,
  output logic [11:0]      column_o,
  output logic [11:0]      image_row_o,
  output logic             last_pixel_o,
  output logic [1:0]       error_code_o
);

  typedef struct packed {
    err_e        code;
    logic        pal;
    rgb_t        rgb;
    logic [11:0] col0;
    logic [11:0] col1;
    logic [11:0] row;
    logic        last0;
    logic        last1;
  } s1_t;

  // Parse state
  logic [31:0] pos_q, pos_d;
  logic [31:0] ofs_q, ofs_d;
  dim_t        wid_q, wid_d, hgt_q, hgt_d;
  logic        wid_hi_q, wid_hi_d, hgt_hi_q, hgt_hi_d;
  logic [15:0] bpp_q, bpp_d;
  dim_t        col_q, col_d, row_q, row_d;
  logic [1:0]  rbm_q, rbm_d;
  logic [15:0] part_q, part_d;
  logic [1:0]  phase_q, phase_d;
  logic        err_q, err_d;

  // Result stage
  logic [1:0]  s1_n_q, s1_n_d;
  s1_t         s1_q, s1_d;

  // Palette memory
  logic        pal_we;
  pal_addr_t   pal_waddr, pal_raddr_a, pal_raddr_b;
  rgb_t        pal_wdata, pal_rdata_a, pal_rdata_b;

  // Helpers
  logic        accept;
  logic        pal_mode, in_pal;
  logic [31:0] pal_end, lim;
  logic [PAL_AW+1:0] pal_rel;
  dim_t        col_p1, col_n, hgt_new, last_col, last_row;
  logic        hgt_hi_new;
  logic [15:0] bpp_new;
  logic [1:0]  rbm_n, phase_n;

  oq_cnt_t     oq_cnt;
  beat_t       beat0, beat1, head;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (oq_cnt + oq_cnt_t'(s1_n_q)) <= oq_cnt_t'(OQ_DEPTH - 2);

  assign pal_mode = (bpp_q == BPP_4) || (bpp_q == BPP_8);
  assign pal_end  = (bpp_q == BPP_4) ? PAL_END_4 : PAL_END_8;
  assign in_pal   = pal_mode && (pos_q >= PAL_BASE) && (pos_q < pal_end);
  assign pal_rel  = pos_q[PAL_AW+1:0] - PAL_BASE[PAL_AW+1:0];
  assign col_p1   = col_q + dim_t'(1);
  assign last_col = wid_q - dim_t'(1);
  assign last_row = hgt_q - dim_t'(1);

  // 4 bpp reads both nibbles in the same cycle, one per read port
  assign pal_raddr_a = (bpp_q == BPP_4) ? pal_addr_t'(file_byte_i[7:4])
                                        : pal_addr_t'(file_byte_i);
  assign pal_raddr_b = pal_addr_t'(file_byte_i[3:0]);

  always_comb begin
    pos_d    = pos_q;
    ofs_d    = ofs_q;
    wid_d    = wid_q;
    hgt_d    = hgt_q;
    wid_hi_d = wid_hi_q;
    hgt_hi_d = hgt_hi_q;
    bpp_d    = bpp_q;
    col_d    = col_q;
    row_d    = row_q;
    rbm_d    = rbm_q;
    part_d   = part_q;
    phase_d  = phase_q;
    err_d    = err_q;
    s1_n_d   = 2'd0;
    s1_d     = s1_q;
    pal_we   = 1'b0;
    pal_waddr = pal_rel[PAL_AW+1:2];
    pal_wdata = {file_byte_i, part_q};

    hgt_new    = dim_merge(hgt_q, 2'd3, file_byte_i);
    hgt_hi_new = hgt_hi_q | dim_spill(2'd3, file_byte_i);
    bpp_new    = {file_byte_i, bpp_q[7:0]};
    lim        = (bpp_new == BPP_4) ? PAL_END_4 :
                 (bpp_new == BPP_8) ? PAL_END_8 : HDR_END;
    col_n      = col_q;
    phase_n    = phase_q;
    rbm_n      = rbm_q + 2'd1;

    if (accept) begin
      pos_d = (&pos_q) ? pos_q : pos_q + 32'd1;
      if (start_of_file_i) begin
        // this byte is byte 0 of a new file
        pos_d    = 32'd1;
        ofs_d    = '0;
        wid_d    = '0;
        hgt_d    = '0;
        wid_hi_d = 1'b0;
        hgt_hi_d = 1'b0;
        bpp_d    = '0;
        col_d    = '0;
        row_d    = '0;
        rbm_d    = '0;
        part_d   = {8'h00, file_byte_i};
        phase_d  = '0;
        err_d    = 1'b0;
      end else if (!err_q) begin
        s1_d.code  = ERR_NONE;
        s1_d.pal   = 1'b0;
        s1_d.rgb   = '0;
        s1_d.col0  = '0;
        s1_d.row   = '0;
        s1_d.last0 = 1'b0;
        if (pos_q < HDR_END) begin
          case (pos_q[4:0])
            POS_SIG1: begin
              if (part_q[7:0] != SIG_B || file_byte_i != SIG_M) begin
                s1_n_d    = 2'd1;
                s1_d.code = ERR_SIGNATURE;
                err_d     = 1'b1;
              end
              part_d = '0;
            end
            POS_OFS0: ofs_d[7:0]   = file_byte_i;
            POS_OFS1: ofs_d[15:8]  = file_byte_i;
            POS_OFS2: ofs_d[23:16] = file_byte_i;
            POS_OFS3: ofs_d[31:24] = file_byte_i;
            POS_WID0, POS_WID1, POS_WID2, POS_WID3: begin
              wid_d    = dim_merge(wid_q, pos_q[1:0] - POS_WID0[1:0], file_byte_i);
              wid_hi_d = wid_hi_q | dim_spill(pos_q[1:0] - POS_WID0[1:0], file_byte_i);
            end
            POS_HGT0, POS_HGT1, POS_HGT2: begin
              hgt_d    = dim_merge(hgt_q, pos_q[1:0] - POS_HGT0[1:0], file_byte_i);
              hgt_hi_d = hgt_hi_q | dim_spill(pos_q[1:0] - POS_HGT0[1:0], file_byte_i);
            end
            POS_HGT3: begin
              hgt_d    = hgt_new;
              hgt_hi_d = hgt_hi_new;
              if (wid_hi_q || (wid_q > dim_t'(MAX_WIDTH)) ||
                  hgt_hi_new || (hgt_new > dim_t'(MAX_HEIGHT))) begin
                s1_n_d    = 2'd1;
                s1_d.code = ERR_SIZE;
                err_d     = 1'b1;
              end
            end
            POS_BPP0: bpp_d[7:0] = file_byte_i;
            POS_BPP1: begin
              bpp_d = bpp_new;
              if (ofs_q < lim) begin
                s1_n_d    = 2'd1;
                s1_d.code = ERR_OFFSET;
                err_d     = 1'b1;
              end
            end
            default: ;
          endcase
        end else if (in_pal) begin
          // entries arrive b,g,r,a; write the whole entry on the red byte
          case (pal_rel[1:0])
            2'd0:    part_d[7:0]  = file_byte_i;
            2'd1:    part_d[15:8] = file_byte_i;
            2'd2:    pal_we       = 1'b1;
            default: ;
          endcase
        end else if ((pos_q >= ofs_q) && (wid_q != '0) && (row_q < hgt_q)) begin
          if (col_q < wid_q) begin
            s1_d.row   = 12'(last_row - row_q);
            s1_d.col0  = 12'(col_q);
            s1_d.col1  = 12'(col_p1);
            s1_d.last0 = (row_q == last_row) && (col_q == last_col);
            s1_d.last1 = (row_q == last_row) && (col_p1 == last_col);
            if (bpp_q == BPP_4) begin
              s1_n_d   = 2'd1;
              s1_d.pal = 1'b1;
              col_n    = col_p1;
              if (col_p1 < wid_q) begin
                s1_n_d = 2'd2;
                col_n  = col_q + dim_t'(2);
              end
            end else if (bpp_q == BPP_8) begin
              s1_n_d   = 2'd1;
              s1_d.pal = 1'b1;
              col_n    = col_p1;
            end else begin
              case (phase_q)
                2'd0: begin
                  part_d  = {8'h00, file_byte_i};
                  phase_n = 2'd1;
                end
                2'd1: begin
                  part_d[15:8] = file_byte_i;
                  phase_n      = 2'd2;
                end
                default: begin
                  s1_n_d   = 2'd1;
                  s1_d.rgb = {file_byte_i, part_q};
                  col_n    = col_p1;
                  part_d   = '0;
                  phase_n  = 2'd0;
                end
              endcase
            end
          end
          rbm_d   = rbm_n;
          phase_d = phase_n;
          // row ends once all pixels are out and the padding is consumed
          if ((col_n >= wid_q) && (rbm_n == 2'd0) && (phase_n == 2'd0)) begin
            row_d = row_q + dim_t'(1);
            col_d = '0;
          end else begin
            col_d = col_n;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      ofs_q    <= '0;
      wid_q    <= '0;
      hgt_q    <= '0;
      wid_hi_q <= 1'b0;
      hgt_hi_q <= 1'b0;
      bpp_q    <= '0;
      col_q    <= '0;
      row_q    <= '0;
      rbm_q    <= '0;
      part_q   <= '0;
      phase_q  <= '0;
      err_q    <= 1'b0;
      s1_n_q   <= '0;
    end else begin
      pos_q    <= pos_d;
      ofs_q    <= ofs_d;
      wid_q    <= wid_d;
      hgt_q    <= hgt_d;
      wid_hi_q <= wid_hi_d;
      hgt_hi_q <= hgt_hi_d;
      bpp_q    <= bpp_d;
      col_q    <= col_d;
      row_q    <= row_d;
      rbm_q    <= rbm_d;
      part_q   <= part_d;
      phase_q  <= phase_d;
      err_q    <= err_d;
      s1_n_q   <= s1_n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
  end

  bmpd_ram #(
    .WIDTH (RGB_W),
    .DEPTH (PAL_DEPTH)
  ) u_palette (
    .clk_i     (clk_i),
    .we_i      (pal_we),
    .waddr_i   (pal_waddr),
    .wdata_i   (pal_wdata),
    .raddr_a_i (pal_raddr_a),
    .rdata_a_o (pal_rdata_a),
    .raddr_b_i (pal_raddr_b),
    .rdata_b_o (pal_rdata_b)
  );

  // Palette data lines up with the result stage
  always_comb begin
    rgb_t rgb0;
    rgb0 = s1_q.pal ? pal_rdata_a : s1_q.rgb;
    beat0.red        = rgb0[23:16];
    beat0.green      = rgb0[15:8];
    beat0.blue       = rgb0[7:0];
    beat0.column     = s1_q.col0;
    beat0.image_row  = s1_q.row;
    beat0.last_pixel = s1_q.last0;
    beat0.error_code = s1_q.code;
    beat1.red        = pal_rdata_b[23:16];
    beat1.green      = pal_rdata_b[15:8];
    beat1.blue       = pal_rdata_b[7:0];
    beat1.column     = s1_q.col1;
    beat1.image_row  = s1_q.row;
    beat1.last_pixel = s1_q.last1;
    beat1.error_code = ERR_NONE;
  end

  bmpd_out_fifo u_out_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (s1_n_q),
    .beat0_i  (beat0),
    .beat1_i  (beat1),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .head_o   (head),
    .count_o  (oq_cnt)
  );

  assign red_o        = head.red;
  assign green_o      = head.green;
  assign blue_o       = head.blue;
  assign column_o     = head.column;
  assign image_row_o  = head.image_row;
  assign last_pixel_o = head.last_pixel;
  assign error_code_o = head.error_code;

endmodule

`default_nettype wire
